[src/tdcrd_pkg.sv]
// ============================================================================
// tdcrd_pkg: shared types and constants of the readout packet decoder
// Word masks, fault bit positions, register indexes and the result beat.
// ============================================================================
package tdcrd_pkg;

   localparam int MAX_WORDS_DEFAULT = 256;

   localparam int WORD_W  = 32;
   localparam int CHAN_W  = 5;
   localparam int TIME_W  = 17;
   localparam int ID_W    = 12;
   localparam int HITS_W  = 9;
   localparam int ERR_W   = 14;
   localparam int FAULT_W = 6;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [HITS_W-1:0] HITS_MAX = '1;

   // Word type masks; inside a packet trailer, error and measurement are tested in that order
   localparam logic [WORD_W-1:0] TRAILER_MASK = 32'hC000_0000;
   localparam logic [WORD_W-1:0] HEADER_MASK  = 32'hA000_0000;
   localparam logic [WORD_W-1:0] ERROR_MASK   = 32'h6000_0000;
   localparam logic [WORD_W-1:0] MEAS_MASK    = 32'h3000_0000;

   // Fault bits of the summary
   localparam logic [FAULT_W-1:0] F_NOHDR = 6'h01;
   localparam logic [FAULT_W-1:0] F_OVF   = 6'h02;
   localparam logic [FAULT_W-1:0] F_COUNT = 6'h04;
   localparam logic [FAULT_W-1:0] F_ID    = 6'h08;
   localparam logic [FAULT_W-1:0] F_BAD   = 6'h10;
   localparam logic [FAULT_W-1:0] F_OFF   = 6'h20;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLED_CHANNEL = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNELS_ON     = 4'd1;

   localparam logic KIND_HIT     = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef struct packed {
      logic [CHAN_W-1:0] enabled_channel;
      logic              channels_on;
   } cfg_type;

   typedef struct packed {
      logic               kind;
      logic [CHAN_W-1:0]  channel;
      logic               edge_res;
      logic               hit_error;
      logic [TIME_W-1:0]  time_count;
      logic               wrong_channel;
      logic [ID_W-1:0]    event_id;
      logic [ID_W-1:0]    bunch_id;
      logic [HITS_W-1:0]  hit_count;
      logic [ERR_W-1:0]   error_flags;
      logic [FAULT_W-1:0] fault_mask;
   } rsp_type;

endpackage

[src/tdcrd_if.sv]
// ============================================================================
// tdcrd_if: valid/ready channels of the readout packet decoder
// Word input, result output and register write channels.
// ============================================================================
interface tdcrd_req_if;
   logic                             valid;
   logic                             ready;
   logic [tdcrd_pkg::WORD_W-1:0]     word;

   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

interface tdcrd_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             kind;
   logic [tdcrd_pkg::CHAN_W-1:0]     channel;
   logic                             edge_res;
   logic                             hit_error;
   logic [tdcrd_pkg::TIME_W-1:0]     time_count;
   logic                             wrong_channel;
   logic [tdcrd_pkg::ID_W-1:0]       event_id;
   logic [tdcrd_pkg::ID_W-1:0]       bunch_id;
   logic [tdcrd_pkg::HITS_W-1:0]     hit_count;
   logic [tdcrd_pkg::ERR_W-1:0]      error_flags;
   logic [tdcrd_pkg::FAULT_W-1:0]    fault_mask;

   modport source (output valid, output kind, output channel, output edge_res,
                   output hit_error, output time_count, output wrong_channel,
                   output event_id, output bunch_id, output hit_count,
                   output error_flags, output fault_mask, input ready);
   modport sink   (input valid, input kind, input channel, input edge_res,
                   input hit_error, input time_count, input wrong_channel,
                   input event_id, input bunch_id, input hit_count,
                   input error_flags, input fault_mask, output ready);
endinterface

interface tdcrd_csr_if;
   logic                              valid;
   logic                              ready;
   logic [tdcrd_pkg::CSR_IDX_W-1:0]   index;
   logic [tdcrd_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[src/tdcrd_csr.sv]
// ============================================================================
// tdcrd_csr: configuration registers
// Holds the enabled channel and the channels-on flag; writes always taken.
// ============================================================================
module tdcrd_csr (
   input  logic                clock,
   input  logic                reset,
   tdcrd_csr_if.sink           csr_bus,
   output tdcrd_pkg::cfg_type  cfg
);

   tdcrd_pkg::cfg_type cfg_ff;
   tdcrd_pkg::cfg_type cfg_in;

   assign csr_bus.ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            tdcrd_pkg::CSR_ENABLED_CHANNEL: begin
               cfg_in.enabled_channel = csr_bus.data[tdcrd_pkg::CHAN_W-1:0];
            end
            tdcrd_pkg::CSR_CHANNELS_ON: begin
               cfg_in.channels_on = csr_bus.data[0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enabled_channel <= '0;
         cfg_ff.channels_on     <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[src/tdcrd_core.sv]
// ============================================================================
// tdcrd_core: packet state and word decode
// Classifies one word per step, updates packet state, forms hit or summary.
// ============================================================================
module tdcrd_core #(
   parameter int MAX_WORDS = tdcrd_pkg::MAX_WORDS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               step,
   input  logic [tdcrd_pkg::WORD_W-1:0]       word,
   input  tdcrd_pkg::cfg_type                 cfg,
   output logic                               res_valid,
   output tdcrd_pkg::rsp_type                 res
);

   localparam int CW   = $clog2(MAX_WORDS + 1);
   localparam int CMPW = (CW > 12) ? CW : 12;
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_WORDS);
   localparam logic [CW-1:0] ONE_CNT = CW'(1);

   logic                           in_pkt_ff,  in_pkt_in;
   logic [CW-1:0]                  cnt_ff,     cnt_in;
   logic [tdcrd_pkg::ID_W-1:0]     eid_ff,     eid_in;
   logic [tdcrd_pkg::ID_W-1:0]     bid_ff,     bid_in;
   logic [tdcrd_pkg::HITS_W-1:0]   hits_ff,    hits_in;
   logic [tdcrd_pkg::ERR_W-1:0]    err_ff,     err_in;
   logic [tdcrd_pkg::FAULT_W-1:0]  fault_ff,   fault_in;

   logic [CW-1:0]                  cnt_next;
   logic [CW-1:0]                  cnt_chk;
   logic                           is_trl, is_hdr, is_err, is_meas;
   logic                           ovf;
   logic [tdcrd_pkg::FAULT_W-1:0]  chk_faults;
   logic [tdcrd_pkg::FAULT_W-1:0]  off_fault;

   assign cnt_next = cnt_ff + ONE_CNT;
   assign cnt_chk  = in_pkt_ff ? cnt_next : ONE_CNT;
   assign ovf      = cnt_chk >= MAX_CNT;

   assign is_trl  = (word & tdcrd_pkg::TRAILER_MASK) == tdcrd_pkg::TRAILER_MASK;
   assign is_hdr  = (word & tdcrd_pkg::HEADER_MASK)  == tdcrd_pkg::HEADER_MASK;
   assign is_err  = (word & tdcrd_pkg::ERROR_MASK)   == tdcrd_pkg::ERROR_MASK;
   assign is_meas = (word & tdcrd_pkg::MEAS_MASK)    == tdcrd_pkg::MEAS_MASK;

   // Trailer checks: word count and event ID
   always_comb begin
      chk_faults = '0;
      if (CMPW'(word[11:0]) != CMPW'(cnt_chk)) begin
         chk_faults = chk_faults | tdcrd_pkg::F_COUNT;
      end
      if (word[23:12] != (in_pkt_ff ? eid_ff : '0)) begin
         chk_faults = chk_faults | tdcrd_pkg::F_ID;
      end
   end

   assign off_fault = cfg.channels_on ? '0 : tdcrd_pkg::F_OFF;

   always_comb begin
      in_pkt_in = in_pkt_ff;
      cnt_in    = cnt_ff;
      eid_in    = eid_ff;
      bid_in    = bid_ff;
      hits_in   = hits_ff;
      err_in    = err_ff;
      fault_in  = fault_ff;
      res_valid = 1'b0;
      res       = '0;
      if (!in_pkt_ff) begin
         if (is_trl) begin
            // Lone trailer: summary of an empty packet
            res_valid      = 1'b1;
            res.kind       = tdcrd_pkg::KIND_SUMMARY;
            res.fault_mask = tdcrd_pkg::F_NOHDR | chk_faults | off_fault
                             | (ovf ? tdcrd_pkg::F_OVF : '0);
            cnt_in   = '0;
            eid_in   = '0;
            bid_in   = '0;
            hits_in  = '0;
            err_in   = '0;
            fault_in = '0;
         end else begin
            in_pkt_in = 1'b1;
            cnt_in    = ONE_CNT;
            eid_in    = word[23:12];
            bid_in    = word[11:0];
            hits_in   = '0;
            err_in    = '0;
            fault_in  = is_hdr ? '0 : tdcrd_pkg::F_NOHDR;
         end
      end else begin
         cnt_in = cnt_next;
         priority if (is_trl || ovf) begin
            res_valid      = 1'b1;
            res.kind       = tdcrd_pkg::KIND_SUMMARY;
            res.event_id   = eid_ff;
            res.bunch_id   = bid_ff;
            res.hit_count  = hits_ff;
            res.error_flags = err_ff;
            res.fault_mask = fault_ff | off_fault
                             | (ovf ? tdcrd_pkg::F_OVF : '0)
                             | (is_trl ? chk_faults : '0);
            in_pkt_in = 1'b0;
            cnt_in    = '0;
            eid_in    = '0;
            bid_in    = '0;
            hits_in   = '0;
            err_in    = '0;
            fault_in  = '0;
         end else if (is_err) begin
            err_in = err_ff | word[tdcrd_pkg::ERR_W-1:0];
         end else if (is_meas) begin
            res_valid         = 1'b1;
            res.kind          = tdcrd_pkg::KIND_HIT;
            res.channel       = word[23:19];
            res.edge_res      = word[18];
            res.hit_error     = word[17];
            res.time_count    = word[16:0];
            res.wrong_channel = word[23:19] != cfg.enabled_channel;
            if (hits_ff != tdcrd_pkg::HITS_MAX) begin
               hits_in = hits_ff + 1'b1;
            end
         end else begin
            fault_in = fault_ff | tdcrd_pkg::F_BAD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_pkt_ff <= 1'b0;
         cnt_ff    <= '0;
         eid_ff    <= '0;
         bid_ff    <= '0;
         hits_ff   <= '0;
         err_ff    <= '0;
         fault_ff  <= '0;
      end else if (step) begin
         in_pkt_ff <= in_pkt_in;
         cnt_ff    <= cnt_in;
         eid_ff    <= eid_in;
         bid_ff    <= bid_in;
         hits_ff   <= hits_in;
         err_ff    <= err_in;
         fault_ff  <= fault_in;
      end
   end

endmodule

[src/tdc_readout_packet_decoder_top.sv]
// ============================================================================
// tdc_readout_packet_decoder_top: readout word stream decoder
// Parses packets of 32-bit readout words into hit and summary beats.
// ============================================================================
//
//   channel   direction  payload                                  role
//   req_bus   in         word[31:0]                               readout words
//   rsp_bus   out        kind, hit fields, summary fields         hit / summary
//   csr_bus   in         index[3:0], data[31:0]                   register writes
//
// One word per cycle sustained while rsp_bus is ready. Each word passes an
// input register, then is decoded against the packet state into the result
// register, which drives the beat. Reset is synchronous and clears the packet
// state, channels_on returns to 1. A stalled rsp_bus holds the result
// register; the input register still takes one more word, and req_bus.ready
// drops only while both registers are full and the result waits.
//
module tdc_readout_packet_decoder_top #(
   parameter int MAX_WORDS = tdcrd_pkg::MAX_WORDS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   tdcrd_req_if.sink    req_bus,
   tdcrd_rsp_if.source  rsp_bus,
   tdcrd_csr_if.sink    csr_bus
);

   tdcrd_pkg::cfg_type             cfg;

   logic                           in_valid_ff;
   logic                           in_valid_in;
   logic [tdcrd_pkg::WORD_W-1:0]   word_ff;

   logic                           rsp_valid_ff;
   logic                           rsp_valid_in;
   tdcrd_pkg::rsp_type             rsp_ff;

   logic                           advance;
   logic                           step;
   logic                           res_valid;
   tdcrd_pkg::rsp_type             res;

   // Advance the pipe whenever the result slot is empty or being drained
   assign advance       = !rsp_valid_ff || rsp_bus.ready;
   assign step          = in_valid_ff && advance;
   assign req_bus.ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_bus.ready) begin
         in_valid_in = req_bus.valid;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = step && res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Load payloads; no reset needed
   always_ff @(posedge clock) begin
      if (req_bus.ready && req_bus.valid) begin
         word_ff <= req_bus.word;
      end
      if (step && res_valid) begin
         rsp_ff <= res;
      end
   end

   tdcrd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   tdcrd_core #(
      .MAX_WORDS (MAX_WORDS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .word      (word_ff),
      .cfg       (cfg),
      .res_valid (res_valid),
      .res       (res)
   );

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.kind          = rsp_ff.kind;
   assign rsp_bus.channel       = rsp_ff.channel;
   assign rsp_bus.edge_res      = rsp_ff.edge_res;
   assign rsp_bus.hit_error     = rsp_ff.hit_error;
   assign rsp_bus.time_count    = rsp_ff.time_count;
   assign rsp_bus.wrong_channel = rsp_ff.wrong_channel;
   assign rsp_bus.event_id      = rsp_ff.event_id;
   assign rsp_bus.bunch_id      = rsp_ff.bunch_id;
   assign rsp_bus.hit_count     = rsp_ff.hit_count;
   assign rsp_bus.error_flags   = rsp_ff.error_flags;
   assign rsp_bus.fault_mask    = rsp_ff.fault_mask;

endmodule

[test/tdcrd_checker.sv]
// ============================================================================
// tdcrd_checker: readout decoder scoreboard
// Watches the word, result and register channels, decodes each accepted word
// against its own packet state and compares every result beat field by field.
// ============================================================================
module tdcrd_checker
   import tdcrd_pkg::*;
#(
   parameter int MAX_WORDS = MAX_WORDS_DEFAULT
) (
   input  logic  clock,
   input  logic  reset,
   tdcrd_req_if  req_bus,
   tdcrd_rsp_if  rsp_bus,
   tdcrd_csr_if  csr_bus,
   output int    fail_count,
   output int    outstanding,
   output int    hit_beats,
   output int    summary_beats
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CNT_W = $clog2(MAX_WORDS + 1);

   // packet state, sized so that a count of MAX_WORDS still fits
   logic                                 open_packet;
   logic [CNT_W-1:0]                     words_in_packet;
   logic [ID_W-1:0]                      event_held;
   logic [ID_W-1:0]                      bunch_held;
   logic [HITS_W-1:0]                    hits_in_packet;
   logic [ERR_W-1:0]                     error_bits;
   logic [FAULT_W-1:0]                   fault_bits;
   cfg_type                              cfg;

   rsp_type predicted_beats[$];
   int      failures = 0;
   int      hits_checked = 0;
   int      summaries_checked = 0;

   assign fail_count    = failures;
   assign hit_beats     = hits_checked;
   assign summary_beats = summaries_checked;

   function automatic void clear_packet();
      open_packet     = 1'b0;
      words_in_packet = '0;
      event_held      = '0;
      bunch_held      = '0;
      hits_in_packet  = '0;
      error_bits      = '0;
      fault_bits      = '0;
   endfunction

   // Build the summary beat and drop back to idle
   function automatic rsp_type close_packet(logic [FAULT_W-1:0] faults);
      rsp_type b;
      b = '0;
      if (!cfg.channels_on) faults |= F_OFF;
      b.kind        = KIND_SUMMARY;
      b.event_id    = event_held;
      b.bunch_id    = bunch_held;
      b.hit_count   = hits_in_packet;
      b.error_flags = error_bits;
      b.fault_mask  = faults;
      clear_packet();
      return b;
   endfunction

   function automatic logic [FAULT_W-1:0] trailer_faults(logic [WORD_W-1:0] w);
      logic [FAULT_W-1:0] f;
      f = '0;
      if (w[11:0] != words_in_packet) f |= F_COUNT;
      if (w[23:12] != event_held)     f |= F_ID;
      return f;
   endfunction

   function automatic void decode_word(input logic [WORD_W-1:0] w,
                                       output rsp_type beat, output bit emits);
      logic               trailer;
      logic [FAULT_W-1:0] f;
      trailer = (w & TRAILER_MASK) == TRAILER_MASK;
      beat    = '0;
      emits   = 1'b0;
      if (!open_packet) begin
         if (trailer) begin
            // a trailer alone forms a whole packet
            clear_packet();
            words_in_packet = CNT_W'(1);
            f = F_NOHDR | trailer_faults(w);
            if (words_in_packet >= MAX_WORDS) f |= F_OVF;
            beat  = close_packet(f);
            emits = 1'b1;
         end else begin
            clear_packet();
            open_packet     = 1'b1;
            words_in_packet = CNT_W'(1);
            event_held      = w[23:12];
            bunch_held      = w[11:0];
            if ((w & HEADER_MASK) != HEADER_MASK) fault_bits |= F_NOHDR;
         end
      end else begin
         words_in_packet = words_in_packet + 1'b1;
         if (trailer) begin
            f = fault_bits | trailer_faults(w);
            if (words_in_packet >= MAX_WORDS) f |= F_OVF;
            beat  = close_packet(f);
            emits = 1'b1;
         end else if (words_in_packet >= MAX_WORDS) begin
            // forced close, the word itself is not decoded
            beat  = close_packet(fault_bits | F_OVF);
            emits = 1'b1;
         end else if ((w & ERROR_MASK) == ERROR_MASK) begin
            error_bits |= w[ERR_W-1:0];
         end else if ((w & MEAS_MASK) == MEAS_MASK) begin
            if (hits_in_packet != HITS_MAX) hits_in_packet = hits_in_packet + 1'b1;
            beat.kind          = KIND_HIT;
            beat.channel       = w[23:19];
            beat.edge_res      = w[18];
            beat.hit_error     = w[17];
            beat.time_count    = w[16:0];
            beat.wrong_channel = w[23:19] != cfg.enabled_channel;
            emits              = 1'b1;
         end else begin
            fault_bits |= F_BAD;
         end
      end
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         failures++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      rsp_type beat;
      bit      emits;
      if (reset) begin
         clear_packet();
         cfg.enabled_channel = '0;
         cfg.channels_on     = 1'b1;
         predicted_beats.delete();
      end else begin
         // compare first: a beat leaving now never belongs to a word taken now
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (predicted_beats.size() == 0) begin
               $error("result beat of kind %0d with nothing pending", rsp_bus.kind);
               failures++;
            end else begin
               want = predicted_beats.pop_front();
               check_field("kind",          want.kind,          rsp_bus.kind);
               check_field("channel",       want.channel,       rsp_bus.channel);
               check_field("edge_res",      want.edge_res,      rsp_bus.edge_res);
               check_field("hit_error",     want.hit_error,     rsp_bus.hit_error);
               check_field("time_count",    want.time_count,    rsp_bus.time_count);
               check_field("wrong_channel", want.wrong_channel, rsp_bus.wrong_channel);
               check_field("event_id",      want.event_id,      rsp_bus.event_id);
               check_field("bunch_id",      want.bunch_id,      rsp_bus.bunch_id);
               check_field("hit_count",     want.hit_count,     rsp_bus.hit_count);
               check_field("error_flags",   want.error_flags,   rsp_bus.error_flags);
               check_field("fault_mask",    want.fault_mask,    rsp_bus.fault_mask);
               if (want.kind == KIND_HIT) hits_checked++;
               else summaries_checked++;
            end
         end
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               CSR_ENABLED_CHANNEL: cfg.enabled_channel = csr_bus.data[CHAN_W-1:0];
               CSR_CHANNELS_ON:     cfg.channels_on     = csr_bus.data[0];
               default: ;
            endcase
         end
         if (req_bus.valid && req_bus.ready) begin
            decode_word(req_bus.word, beat, emits);
            if (emits) predicted_beats.push_back(beat);
         end
      end
      outstanding = predicted_beats.size();
   end

endmodule

[test/tb.sv]
// ============================================================================
// tb: readout packet decoder testbench
// Streams directed and random readout packets into the decoder under several
// register settings, with random gaps and stalls, and lets the checker score
// every hit and summary beat.
// ============================================================================
module tb;
   import tdcrd_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_WORDS   = MAX_WORDS_DEFAULT;
   localparam int ITEM_TARGET = 1800;
   localparam int PHASES      = 6;
   // time for a word to pass the input and result registers, plus margin
   localparam int SETTLE      = 6;
   // keep a wide margin over the slowest run
   localparam int CYCLE_LIMIT = 200000;

   logic clock;
   logic reset;

   tdcrd_req_if req_bus ();
   tdcrd_rsp_if rsp_bus ();
   tdcrd_csr_if csr_bus ();

   int fail_count;
   int outstanding;
   int hit_beats;
   int summary_beats;

   int          words_sent  = 0;
   int          cycle_count = 0;
   bit          steady      = 1'b0;   // no gaps and no stalls while set
   logic [4:0]  en_chan     = '0;     // our copy of enabled_channel, to bias hits

   tdc_readout_packet_decoder_top #(.MAX_WORDS(MAX_WORDS)) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   tdcrd_checker #(.MAX_WORDS(MAX_WORDS)) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_bus       (req_bus),
      .rsp_bus       (rsp_bus),
      .csr_bus       (csr_bus),
      .fail_count    (fail_count),
      .outstanding   (outstanding),
      .hit_beats     (hit_beats),
      .summary_beats (summary_beats)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Hard stop: a hung handshake or a lost beat ends here
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Result side: random stalls, drawn with a chance of 8 in a hundred, never while steady
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready = steady || ($urandom_range(0, 99) >= 8);
      end
   end

   // ---------------------------------------------------------------------
   // Word builders. The top bits pick the word type; the decoder tests
   // trailer, then error, then measurement inside a packet.
   // ---------------------------------------------------------------------
   function automatic logic [31:0] header_word(logic [11:0] eid, logic [11:0] bunch);
      return {3'b101, 1'($urandom), 4'($urandom), eid, bunch};
   endfunction

   // opener that fails the header test but is not a trailer either
   function automatic logic [31:0] non_header_word();
      if ($urandom_range(0, 1)) return {1'b0, 31'($urandom)};
      return {3'b100, 29'($urandom)};
   endfunction

   function automatic logic [31:0] meas_word(logic [4:0] ch);
      // 0011 or 1011: not a trailer, not an error word
      return {1'($urandom), 3'b011, 4'($urandom), ch, 19'($urandom)};
   endfunction

   function automatic logic [31:0] error_word();
      return {3'b011, 29'($urandom)};
   endfunction

   function automatic logic [31:0] trailer_word(logic [11:0] eid, logic [11:0] count);
      return {2'b11, 6'($urandom), eid, count};
   endfunction

   // top nibbles that match no trailer, error or measurement word
   function automatic logic [31:0] bad_word();
      logic [3:0] nib [8] = '{4'h0, 4'h1, 4'h2, 4'h4, 4'h5, 4'h8, 4'h9, 4'hA};
      return {nib[$urandom_range(0, 7)], 28'($urandom)};
   endfunction

   // ---------------------------------------------------------------------
   // Channel drivers. Drive at the falling edge, sample ready at the rising
   // edge. Valid stays high from one beat to the next unless a gap is drawn.
   // ---------------------------------------------------------------------
   task automatic send_word(input logic [31:0] w);
      @(negedge clock);
      if (!steady && $urandom_range(0, 99) < 4) begin
         req_bus.valid = 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.word  = w;
      do @(posedge clock); while (!req_bus.ready);
      words_sent++;
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_bus.valid = 1'b1;
      csr_bus.index = idx;
      csr_bus.data  = value;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   // Drop valid, wait for every predicted beat, then let the pipe empty of
   // words that produce nothing (headers, error words, bad words).
   task automatic drain();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   // One packet: opener, body_len body words, trailer.
   task automatic send_packet(input int body_len, input bit hdr_ok,
                              input bit count_ok, input bit id_ok);
      logic [31:0] opener;
      int          pick;
      opener = hdr_ok ? header_word(12'($urandom), 12'($urandom)) : non_header_word();
      send_word(opener);
      for (int i = 0; i < body_len; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 62)
            send_word(meas_word($urandom_range(0, 1) ? en_chan : 5'($urandom)));
         else if (pick < 84)
            send_word(error_word());
         else
            send_word(bad_word());
      end
      // a correct trailer counts opener and trailer too
      send_word(trailer_word(id_ok ? opener[23:12] : 12'($urandom),
                             count_ok ? 12'(body_len + 2) : 12'($urandom)));
   endtask

   task automatic set_registers(input logic [4:0] ch, input logic on);
      // upper data bits are random: the registers must ignore them
      write_csr(CSR_ENABLED_CHANNEL, {27'($urandom), ch});
      write_csr(CSR_CHANNELS_ON, {31'($urandom), on});
      en_chan = ch;
   endtask

   initial begin
      int          target;
      int          pick;
      int          body_len;
      logic [4:0]  ch;
      logic        on;

      reset         = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.word  = '0;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_ENABLED_CHANNEL;
      csr_bus.data  = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // -------------------------------------------------------------------
      // Directed beats under reset settings (channel 0, channels on)
      // -------------------------------------------------------------------
      send_word(32'hC000_0001);   // trailer while idle, count and ID right
      send_word(32'hFFFF_FFFF);   // trailer while idle, count and ID wrong
      send_word(32'hAFFF_FFFF);   // header with all-ones IDs
      send_word(32'h3FFF_FFFF);   // hit, channel 31, all fields high
      send_word(32'hB000_0000);   // hit, channel 0, bit 31 set, fields low
      send_word(32'h7FFF_FFFF);   // error word carrying every flag
      send_word(32'h6000_0000);   // error word with no flags
      send_word(32'h0000_0000);   // bad word
      send_word(32'hC0FF_F007);   // trailer: 7 words, event ID matches
      send_word(32'h1234_5678);   // opener that is no header
      send_word(32'h3A5A_5A5A);   // hit inside that packet
      send_word(32'hC000_0000);   // trailer with wrong count and wrong ID
      send_word(32'hA0AB_C123);   // header
      send_word(32'hC0AB_C002);   // empty packet, clean trailer
      drain();

      // -------------------------------------------------------------------
      // Random phases, one register setting each
      // -------------------------------------------------------------------
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: begin ch = 5'd31;        on = 1'b0; end
            1: begin ch = 5'd0;         on = 1'b1; end
            2: begin ch = 5'($urandom); on = 1'b1; end
            3: begin ch = 5'd31;        on = 1'b1; end
            4: begin ch = 5'($urandom); on = 1'b0; end
            default: begin ch = 5'd0;   on = 1'b0; end
         endcase
         set_registers(ch, on);
         // one phase runs without any gaps or stalls
         steady = (p == 2);
         target = words_sent + ITEM_TARGET / PHASES;

         // Long packets reach the word limit: trailer one short of it,
         // trailer right on it, and a body word on it (forced close).
         if (p % 2 == 1)
            send_packet(MAX_WORDS - 3 + p / 2, 1'b1, 1'b1, 1'b1);

         while (words_sent < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
               body_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60)
                                                      : $urandom_range(0, 12);
               send_packet(body_len, $urandom_range(0, 99) < 90,
                           $urandom_range(0, 99) < 85, $urandom_range(0, 99) < 85);
            end else if (pick < 88) begin
               // lone trailer, each half the time with the count and the ID an idle decoder holds
               send_word(trailer_word($urandom_range(0, 1) ? 12'h000 : 12'($urandom),
                                      $urandom_range(0, 1) ? 12'd1 : 12'($urandom)));
            end else begin
               // raw noise: anything goes
               repeat ($urandom_range(1, 4)) send_word($urandom);
            end
         end
         drain();
      end
      steady = 1'b0;

      $display("Sent %0d readout words over %0d register settings, long packets included;",
               words_sent, PHASES + 1);
      $display("checked %0d hit beats and %0d packet summaries.", hit_beats, summary_beats);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

[filelist.f]
src/tdcrd_pkg.sv
src/tdcrd_if.sv
src/tdcrd_csr.sv
src/tdcrd_core.sv
src/tdc_readout_packet_decoder_top.sv
test/tdcrd_checker.sv
test/tb.sv
